// ===== design/hir_pkg.sv =====
// Package for the hashed identity registry: types, codes and constants.
package hir_pkg;

	localparam int TABLE_SLOTS_DEF = 256;

	localparam logic [63:0] HASH_MUL_SIG  = 64'h9E3779B185EBCA87;
	localparam logic [63:0] HASH_MUL_KIND = 64'hC2B2AE3D27D4EB4F;

	localparam logic [2:0] FN_RESOLVE  = 3'd0;
	localparam logic [2:0] FN_BIND     = 3'd1;
	localparam logic [2:0] FN_BEGIN    = 3'd2;
	localparam logic [2:0] FN_COMMIT   = 3'd3;
	localparam logic [2:0] FN_ROLLBACK = 3'd4;
	localparam logic [2:0] FN_CLEAR    = 3'd5;

	localparam logic [3:0] ST_ALLOCATED    = 4'd0;
	localparam logic [3:0] ST_EXISTING     = 4'd1;
	localparam logic [3:0] ST_BOUND        = 4'd2;
	localparam logic [3:0] ST_BAD_KEY      = 4'd3;
	localparam logic [3:0] ST_BAD_ID       = 4'd4;
	localparam logic [3:0] ST_KEY_CONFLICT = 4'd5;
	localparam logic [3:0] ST_ID_CONFLICT  = 4'd6;
	localparam logic [3:0] ST_FULL         = 4'd7;
	localparam logic [3:0] ST_COUNTER      = 4'd8;
	localparam logic [3:0] ST_OK           = 4'd9;
	localparam logic [3:0] ST_IGNORED      = 4'd10;

	typedef struct packed {
		logic [2:0]  func;
		logic [63:0] signature;
		logic [31:0] object_kind;
		logic [63:0] bind_id;
	} req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [63:0] ident;
		logic [8:0]  count_now;
		logic [63:0] last_id_now;
		logic        in_transaction;
	} rsp_t;

	typedef struct packed {
		logic [63:0] signature;
		logic [31:0] object_kind;
		logic [63:0] entity;
	} slot_t;

endpackage

// ===== design/hir_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module hir_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/hir_hash.sv =====
// Home slot hash: two 64-bit multiplies done over cycles on one 32x32 multiplier.
module hir_hash #(
	parameter int TABLE_SLOTS = hir_pkg::TABLE_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [63:0]                    signature,
	input  logic [31:0]                    object_kind,
	output logic                           done,
	output logic [$clog2(TABLE_SLOTS)-1:0] home
);
	localparam int IW = $clog2(TABLE_SLOTS);
	localparam logic [IW-1:0] MASK = IW'(TABLE_SLOTS - 1);

	logic [2:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] op_a, op_b;
	logic [63:0] prod_q;
	logic [63:0] acc_sig_q, acc_kind_q;
	logic [63:0] m, fold;

	always_comb begin
		op_a = signature[31:0];
		op_b = hir_pkg::HASH_MUL_SIG[31:0];
		case (step_q)
			3'd0: begin op_a = signature[31:0];  op_b = hir_pkg::HASH_MUL_SIG[31:0];  end
			3'd1: begin op_a = signature[31:0];  op_b = hir_pkg::HASH_MUL_SIG[63:32]; end
			3'd2: begin op_a = signature[63:32]; op_b = hir_pkg::HASH_MUL_SIG[31:0];  end
			3'd3: begin op_a = object_kind;      op_b = hir_pkg::HASH_MUL_KIND[31:0]; end
			default: begin op_a = object_kind;   op_b = hir_pkg::HASH_MUL_KIND[63:32]; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The product of one step is added in on the following step.
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		if (busy_q) begin
			case (step_q)
				3'd1: acc_sig_q  <= prod_q;
				3'd2: acc_sig_q  <= acc_sig_q + {prod_q[31:0], 32'd0};
				3'd3: acc_sig_q  <= acc_sig_q + {prod_q[31:0], 32'd0};
				3'd4: acc_kind_q <= prod_q;
				3'd5: acc_kind_q <= acc_kind_q + {prod_q[31:0], 32'd0};
				default: ;
			endcase
		end
	end

	assign m    = acc_sig_q ^ acc_kind_q;
	assign fold = m ^ (m >> 32);
	assign home = fold[IW-1:0] & MASK;
	assign done = done_q;
endmodule

// ===== design/hashed_identity_registry.sv =====
// Top level of the hashed identity registry: control sequencer around the slot and journal RAMs.
//
// Channel  Direction  Payload            Handshake
// req      in         hir_pkg::req_t     req_valid / req_stall
// rsp      out        hir_pkg::rsp_t     rsp_valid / rsp_stall
//
// One transaction at a time; req_stall stays high until the result is in the output register.
// Begin, commit, clear, unused codes and rejected keys go straight to the result.
// Resolve and bind hash the key, then probe the slots from its home slot onward;
// a bind of a new key then scans the slot RAM for its identifier.
// Rollback frees every journalled slot and restores the saved count and last id.
// Reset empties the table at once; a stalled result waits in the output register.
module hashed_identity_registry #(
	parameter int TABLE_SLOTS = hir_pkg::TABLE_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  hir_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output hir_pkg::rsp_t rsp
);
	localparam int IW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam logic [IW-1:0] MASK = IW'(TABLE_SLOTS - 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_SLOTS);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_HASH   = 3'd1;
	localparam logic [2:0] S_PROBE  = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_DECIDE = 3'd4;
	localparam logic [2:0] S_RB     = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0]             state_q;
	hir_pkg::req_t          req_q;
	logic [3:0]             status_q;
	logic [63:0]            eid_q;
	logic [TABLE_SLOTS-1:0] used_q;
	logic [CW-1:0]          count_q, saved_count_q;
	logic [63:0]            last_id_q, saved_last_id_q;
	logic [CW-1:0]          jlen_q;
	logic                   txn_q;
	logic [IW-1:0]          idx_q, cnt_q;
	logic                   hit_q, free_ok_q, scanned_q;
	logic [IW-1:0]          free_idx_q;
	logic [63:0]            ent_q;
	logic [CW-1:0]          rb_i_q;
	logic                   rb_v_q;
	logic                   out_valid_q;
	hir_pkg::rsp_t          out_q;

	logic                   hash_start, hash_done;
	logic [IW-1:0]          home;
	logic                   slot_we;
	logic [IW-1:0]          slot_raddr;
	hir_pkg::slot_t         slot_wdata, slot_rdata;
	logic                   jr_we;
	logic [IW-1:0]          jr_rdata;
	logic [IW-1:0]          idx_inc, idx_next;
	logic                   accept, load_out, key_ok, fill;
	logic [63:0]            fill_id;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign key_ok    = (req.signature != 64'd0) && (req.object_kind != 32'd0);
	assign idx_inc   = idx_q + IW'(1);
	assign idx_next  = idx_inc & MASK;
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || !rsp_stall);
	assign hash_start = accept && key_ok &&
		((req.func == hir_pkg::FN_RESOLVE) ||
		 ((req.func == hir_pkg::FN_BIND) && (req.bind_id != 64'd0)));

	// A slot is filled from the decide state when every check has passed.
	always_comb begin
		fill    = 1'b0;
		fill_id = req_q.bind_id;
		if (state_q == S_DECIDE && !hit_q) begin
			if (req_q.func == hir_pkg::FN_RESOLVE) begin
				fill    = (count_q < FULL_CNT) && !(&last_id_q) && free_ok_q;
				fill_id = last_id_q + 64'd1;
			end else if (scanned_q) begin
				fill = (count_q < FULL_CNT) && free_ok_q;
			end
		end
	end

	assign slot_we    = fill;
	assign slot_wdata = '{signature: req_q.signature, object_kind: req_q.object_kind,
		entity: fill_id};
	assign jr_we      = fill && txn_q && (jlen_q < FULL_CNT);

	always_comb begin
		slot_raddr = idx_q;
		if (state_q == S_HASH) begin
			slot_raddr = home;
		end else if (state_q == S_PROBE) begin
			slot_raddr = idx_next;
		end else if (state_q == S_SCAN) begin
			slot_raddr = idx_inc;
		end else if (state_q == S_DECIDE) begin
			slot_raddr = '0;
		end
	end

	hir_hash #(.TABLE_SLOTS(TABLE_SLOTS)) u_hash (
		.clk(clk), .arst_n(arst_n), .start(hash_start),
		.signature(req_q.signature), .object_kind(req_q.object_kind),
		.done(hash_done), .home(home)
	);

	hir_ram #(.WIDTH($bits(hir_pkg::slot_t)), .DEPTH(TABLE_SLOTS)) u_slot_ram (
		.clk(clk), .we(slot_we), .waddr(free_idx_q), .wdata(slot_wdata),
		.raddr(slot_raddr), .rdata(slot_rdata)
	);

	hir_ram #(.WIDTH(IW), .DEPTH(TABLE_SLOTS)) u_journal_ram (
		.clk(clk), .we(jr_we), .waddr(jlen_q[IW-1:0]), .wdata(free_idx_q),
		.raddr(rb_i_q[IW-1:0]), .rdata(jr_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			used_q          <= '0;
			count_q         <= '0;
			last_id_q       <= '0;
			saved_count_q   <= '0;
			saved_last_id_q <= '0;
			jlen_q          <= '0;
			txn_q           <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			if (fill) begin
				used_q[free_idx_q] <= 1'b1;
				count_q <= count_q + CW'(1);
				if (jr_we) begin
					jlen_q <= jlen_q + CW'(1);
				end
				if (req_q.func == hir_pkg::FN_RESOLVE || req_q.bind_id > last_id_q) begin
					last_id_q <= fill_id;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DONE;
						if (hash_start) begin
							state_q <= S_HASH;
						end else if (req.func == hir_pkg::FN_BEGIN && !txn_q) begin
							jlen_q          <= '0;
							saved_count_q   <= count_q;
							saved_last_id_q <= last_id_q;
							txn_q           <= 1'b1;
						end else if (req.func == hir_pkg::FN_COMMIT && txn_q) begin
							jlen_q <= '0;
							txn_q  <= 1'b0;
						end else if (req.func == hir_pkg::FN_ROLLBACK && txn_q) begin
							state_q <= S_RB;
						end else if (req.func == hir_pkg::FN_CLEAR) begin
							used_q    <= '0;
							count_q   <= '0;
							last_id_q <= '0;
						end
					end
				end
				S_HASH: begin
					if (hash_done) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (!used_q[idx_q] || (slot_rdata.signature == req_q.signature &&
						slot_rdata.object_kind == req_q.object_kind) || cnt_q == LAST_IDX) begin
						state_q <= S_DECIDE;
					end
				end
				S_SCAN: begin
					if ((used_q[idx_q] && slot_rdata.entity == req_q.bind_id) ||
						idx_q == LAST_IDX) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (req_q.func == hir_pkg::FN_BIND && !hit_q && !scanned_q) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RB: begin
					if (rb_v_q) begin
						used_q[jr_rdata & MASK] <= 1'b0;
					end
					if (!rb_v_q && rb_i_q >= jlen_q) begin
						count_q   <= saved_count_q;
						last_id_q <= saved_last_id_q;
						jlen_q    <= '0;
						txn_q     <= 1'b0;
						state_q   <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers; their control is covered by the state register.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req;
			status_q  <= hir_pkg::ST_IGNORED;
			eid_q     <= '0;
			scanned_q <= 1'b0;
			rb_i_q    <= '0;
			rb_v_q    <= 1'b0;
			if (req.func == hir_pkg::FN_RESOLVE || req.func == hir_pkg::FN_BIND) begin
				if (!key_ok) begin
					status_q <= hir_pkg::ST_BAD_KEY;
				end else if (req.func == hir_pkg::FN_BIND && req.bind_id == 64'd0) begin
					status_q <= hir_pkg::ST_BAD_ID;
				end
			end else if ((req.func == hir_pkg::FN_BEGIN && !txn_q) ||
				((req.func == hir_pkg::FN_COMMIT || req.func == hir_pkg::FN_ROLLBACK) && txn_q) ||
				req.func == hir_pkg::FN_CLEAR) begin
				status_q <= hir_pkg::ST_OK;
			end
		end
		if (state_q == S_HASH && hash_done) begin
			idx_q <= home;
			cnt_q <= '0;
		end
		if (state_q == S_PROBE) begin
			hit_q      <= 1'b0;
			free_ok_q  <= 1'b0;
			free_idx_q <= idx_q;
			ent_q      <= slot_rdata.entity;
			if (!used_q[idx_q]) begin
				free_ok_q <= 1'b1;
			end else if (slot_rdata.signature == req_q.signature &&
				slot_rdata.object_kind == req_q.object_kind) begin
				hit_q <= 1'b1;
			end else if (cnt_q != LAST_IDX) begin
				idx_q <= idx_next;
				cnt_q <= cnt_q + IW'(1);
			end
		end
		if (state_q == S_DECIDE) begin
			idx_q <= '0;
			if (req_q.func == hir_pkg::FN_RESOLVE) begin
				if (hit_q) begin
					status_q <= hir_pkg::ST_EXISTING;
					eid_q    <= ent_q;
				end else if (count_q >= FULL_CNT) begin
					status_q <= hir_pkg::ST_FULL;
				end else if (&last_id_q) begin
					status_q <= hir_pkg::ST_COUNTER;
				end else if (!free_ok_q) begin
					status_q <= hir_pkg::ST_FULL;
				end else begin
					status_q <= hir_pkg::ST_ALLOCATED;
					eid_q    <= fill_id;
				end
			end else if (hit_q && !scanned_q) begin
				if (ent_q == req_q.bind_id) begin
					status_q <= hir_pkg::ST_EXISTING;
					eid_q    <= req_q.bind_id;
				end else begin
					status_q <= hir_pkg::ST_KEY_CONFLICT;
				end
			end else if (scanned_q && !hit_q) begin
				// A hit from the identifier scan keeps its id conflict status.
				if (fill) begin
					status_q <= hir_pkg::ST_BOUND;
					eid_q    <= req_q.bind_id;
				end else begin
					status_q <= hir_pkg::ST_FULL;
				end
			end
		end
		if (state_q == S_SCAN) begin
			if (used_q[idx_q] && slot_rdata.entity == req_q.bind_id) begin
				status_q  <= hir_pkg::ST_ID_CONFLICT;
				hit_q     <= 1'b1;
				ent_q     <= 64'd0;
				scanned_q <= 1'b1;
			end else if (idx_q == LAST_IDX) begin
				scanned_q <= 1'b1;
			end else begin
				idx_q <= idx_inc;
			end
		end
		if (state_q == S_RB) begin
			if (rb_i_q < jlen_q) begin
				rb_i_q <= rb_i_q + CW'(1);
				rb_v_q <= 1'b1;
			end else begin
				rb_v_q <= 1'b0;
			end
		end
		if (load_out) begin
			out_q.status         <= status_q;
			out_q.ident          <= eid_q;
			out_q.count_now      <= 9'(count_q);
			out_q.last_id_now    <= last_id_q;
			out_q.in_transaction <= txn_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
endmodule

// ===== design/hir_checker.sv =====
// Port-level checker for the hashed identity registry, bound to the top level.
module hir_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input hir_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input hir_pkg::rsp_t rsp
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while one is in progress");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.count_now <= 9'(hir_pkg::TABLE_SLOTS_DEF))
		else $error("occupancy out of range");

	a_alloc_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == hir_pkg::ST_ALLOCATED |->
		rsp.ident == rsp.last_id_now && rsp.ident != 64'd0)
		else $error("allocated id differs from last id");
endmodule

bind hashed_identity_registry hir_checker u_hir_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the hashed identity registry: predictor, scoreboard and drivers.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = hir_pkg::TABLE_SLOTS_DEF;
	localparam int NUM_RANDOM = 700;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	hir_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	hir_pkg::rsp_t rsp;

	int errors = 0;
	longint cycles = 0;
	bit quiet = 1'b0;

	hashed_identity_registry #(.TABLE_SLOTS(SLOTS)) i_dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
	endtask

	// Scoreboard with its own copy of the registry state.
	class registry_board;
		bit          used [SLOTS];
		logic [63:0] sig_of [SLOTS];
		logic [31:0] kind_of [SLOTS];
		logic [63:0] id_of [SLOTS];
		int          count;
		logic [63:0] last_id;
		int          journal [SLOTS];
		int          jlen;
		bit          open;
		int          saved_count;
		logic [63:0] saved_last;
		hir_pkg::rsp_t pending [$];

		function int home(logic [63:0] s, logic [31:0] k);
			logic [63:0] m;
			m = (s * hir_pkg::HASH_MUL_SIG) ^ ({32'd0, k} * hir_pkg::HASH_MUL_KIND);
			return int'((m ^ (m >> 32)) & 64'(SLOTS - 1));
		endfunction

		function int find_key(logic [63:0] s, logic [31:0] k);
			int idx;
			idx = home(s, k);
			for (int p = 0; p < SLOTS; p++) begin
				if (!used[idx]) return -1;
				if (sig_of[idx] == s && kind_of[idx] == k) return idx;
				idx = (idx + 1) & (SLOTS - 1);
			end
			return -1;
		endfunction

		function int find_free(logic [63:0] s, logic [31:0] k);
			int idx;
			idx = home(s, k);
			for (int p = 0; p < SLOTS; p++) begin
				if (!used[idx]) return idx;
				idx = (idx + 1) & (SLOTS - 1);
			end
			return -1;
		endfunction

		function void fill(int idx, logic [63:0] s, logic [31:0] k, logic [63:0] id);
			used[idx] = 1; sig_of[idx] = s; kind_of[idx] = k; id_of[idx] = id;
			if (open && jlen < SLOTS) begin
				journal[jlen] = idx;
				jlen++;
			end
			count++;
		endfunction

		function void note_request(hir_pkg::req_t r);
			hir_pkg::rsp_t o;
			int idx;
			bit key_ok;
			bit taken;
			o = '0;
			o.status = hir_pkg::ST_IGNORED;
			key_ok = r.signature != 0 && r.object_kind != 0;
			case (r.func)
				hir_pkg::FN_RESOLVE: begin
					idx = key_ok ? find_key(r.signature, r.object_kind) : -1;
					if (!key_ok) o.status = hir_pkg::ST_BAD_KEY;
					else if (idx >= 0) begin
						o.status = hir_pkg::ST_EXISTING; o.ident = id_of[idx];
					end else if (count >= SLOTS) o.status = hir_pkg::ST_FULL;
					else if (last_id == '1) o.status = hir_pkg::ST_COUNTER;
					else begin
						idx = find_free(r.signature, r.object_kind);
						if (idx < 0) o.status = hir_pkg::ST_FULL;
						else begin
							last_id++;
							fill(idx, r.signature, r.object_kind, last_id);
							o.status = hir_pkg::ST_ALLOCATED; o.ident = last_id;
						end
					end
				end
				hir_pkg::FN_BIND: begin
					idx = (key_ok && r.bind_id != 0) ? find_key(r.signature, r.object_kind) : -1;
					taken = 0;
					for (int i = 0; i < SLOTS; i++)
						if (used[i] && id_of[i] == r.bind_id) taken = 1;
					if (!key_ok) o.status = hir_pkg::ST_BAD_KEY;
					else if (r.bind_id == 0) o.status = hir_pkg::ST_BAD_ID;
					else if (idx >= 0) begin
						if (id_of[idx] == r.bind_id) begin
							o.status = hir_pkg::ST_EXISTING; o.ident = r.bind_id;
						end else o.status = hir_pkg::ST_KEY_CONFLICT;
					end else if (taken) o.status = hir_pkg::ST_ID_CONFLICT;
					else if (count >= SLOTS) o.status = hir_pkg::ST_FULL;
					else begin
						idx = find_free(r.signature, r.object_kind);
						if (idx < 0) o.status = hir_pkg::ST_FULL;
						else begin
							fill(idx, r.signature, r.object_kind, r.bind_id);
							if (r.bind_id > last_id) last_id = r.bind_id;
							o.status = hir_pkg::ST_BOUND; o.ident = r.bind_id;
						end
					end
				end
				hir_pkg::FN_BEGIN: if (!open) begin
					jlen = 0; saved_count = count; saved_last = last_id; open = 1;
					o.status = hir_pkg::ST_OK;
				end
				hir_pkg::FN_COMMIT: if (open) begin
					jlen = 0; open = 0; o.status = hir_pkg::ST_OK;
				end
				hir_pkg::FN_ROLLBACK: if (open) begin
					for (int i = 0; i < jlen; i++) used[journal[i]] = 0;
					count = saved_count; last_id = saved_last; jlen = 0; open = 0;
					o.status = hir_pkg::ST_OK;
				end
				hir_pkg::FN_CLEAR: begin
					foreach (used[i]) used[i] = 0;
					count = 0; last_id = 0; o.status = hir_pkg::ST_OK;
				end
				default: ;
			endcase
			o.count_now = 9'(count);
			o.last_id_now = last_id;
			o.in_transaction = open;
			pending.push_back(o);
		endfunction

		task check_response(hir_pkg::rsp_t got);
			hir_pkg::rsp_t want;
			if (pending.size() == 0) begin
				report("unexpected response", got.status, 0);
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) report("status", got.status, want.status);
			if (got.ident !== want.ident) report("ident", got.ident, want.ident);
			if (got.count_now !== want.count_now) report("count_now", got.count_now, want.count_now);
			if (got.last_id_now !== want.last_id_now)
				report("last_id_now", got.last_id_now, want.last_id_now);
			if (got.in_transaction !== want.in_transaction)
				report("in_transaction", got.in_transaction, want.in_transaction);
		endtask
	endclass

	registry_board board = new();

	// Small pools of keys so that hits, conflicts and probe chains are common.
	logic [63:0] sig_pool [16];
	logic [31:0] kind_pool [4];
	logic [63:0] id_pool [8];

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n && rsp_valid && !rsp_stall) board.check_response(rsp);
		if (arst_n && req_valid && !req_stall) board.note_request(req);
	end

	// Receiver stall bursts.
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 19);
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
		end
	end

	// The stall is looked at on the falling edge, where it is settled for the next rising edge.
	task automatic send(input hir_pkg::req_t r);
		int n;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 19);
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(negedge clk);
		while (req_stall) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_op(input logic [2:0] f, input logic [63:0] s, input logic [31:0] k,
			input logic [63:0] id);
		hir_pkg::req_t r;
		r.func = f; r.signature = s; r.object_kind = k; r.bind_id = id;
		send(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	function automatic hir_pkg::req_t random_req();
		hir_pkg::req_t r;
		int pick;
		r.signature = $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : sig_pool[$urandom_range(0, 15)];
		r.object_kind = $urandom_range(0, 3) == 0 ? $urandom : kind_pool[$urandom_range(0, 3)];
		r.bind_id = $urandom_range(0, 2) == 0 ? {$urandom, $urandom} : id_pool[$urandom_range(0, 7)];
		if ($urandom_range(0, 40) == 0) r.signature = '0;
		if ($urandom_range(0, 40) == 0) r.object_kind = '0;
		if ($urandom_range(0, 40) == 0) r.bind_id = '0;
		pick = $urandom_range(0, 99);
		if (pick < 45) r.func = hir_pkg::FN_RESOLVE;
		else if (pick < 70) r.func = hir_pkg::FN_BIND;
		else if (pick < 80) r.func = hir_pkg::FN_BEGIN;
		else if (pick < 86) r.func = hir_pkg::FN_COMMIT;
		else if (pick < 92) r.func = hir_pkg::FN_ROLLBACK;
		else if (pick < 95) r.func = hir_pkg::FN_CLEAR;
		else r.func = 3'($urandom_range(6, 7));
		return r;
	endfunction

	initial begin
		foreach (sig_pool[i]) sig_pool[i] = {$urandom, $urandom} | 64'd1;
		foreach (kind_pool[i]) kind_pool[i] = $urandom | 32'd1;
		foreach (id_pool[i]) id_pool[i] = {$urandom, $urandom} | 64'd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: bad keys, bad id, allocation, hits, conflicts.
		send_op(hir_pkg::FN_RESOLVE, 64'd0, 32'd1, 64'd0);
		send_op(hir_pkg::FN_RESOLVE, 64'd1, 32'd0, 64'd0);
		send_op(hir_pkg::FN_BIND, 64'd5, 32'd5, 64'd0);
		send_op(hir_pkg::FN_RESOLVE, '1, '1, '1);
		send_op(hir_pkg::FN_RESOLVE, '1, '1, 64'd0);
		send_op(hir_pkg::FN_BIND, '1, '1, 64'd1);
		send_op(hir_pkg::FN_BIND, '1, '1, 64'd9);
		send_op(hir_pkg::FN_BIND, 64'd7, 32'd7, 64'd1);
		send_op(hir_pkg::FN_BIND, 64'd8, 32'd8, '1);
		// Counter is now exhausted for new keys.
		send_op(hir_pkg::FN_RESOLVE, 64'd9, 32'd9, 64'd0);
		send_op(hir_pkg::FN_COMMIT, 64'd0, 32'd0, 64'd0);
		send_op(hir_pkg::FN_ROLLBACK, 64'd0, 32'd0, 64'd0);
		send_op(hir_pkg::FN_BEGIN, 64'd0, 32'd0, 64'd0);
		send_op(hir_pkg::FN_BEGIN, 64'd0, 32'd0, 64'd0);
		send_op(hir_pkg::FN_BIND, 64'd10, 32'd10, 64'd100);
		send_op(hir_pkg::FN_ROLLBACK, 64'd0, 32'd0, 64'd0);
		send_op(hir_pkg::FN_BEGIN, 64'd0, 32'd0, 64'd0);
		send_op(hir_pkg::FN_CLEAR, 64'd0, 32'd0, 64'd0);
		send_op(hir_pkg::FN_RESOLVE, 64'd11, 32'd11, 64'd0);
		send_op(hir_pkg::FN_COMMIT, 64'd0, 32'd0, 64'd0);
		send_op(3'd6, '1, '1, '1);
		send_op(3'd7, 64'd0, 32'd0, 64'd0);
		drain();

		// Fill the table completely inside a transaction, overflow, then roll back and clear.
		quiet = 1'b1;
		send_op(hir_pkg::FN_BEGIN, 64'd0, 32'd0, 64'd0);
		for (int i = 0; i < SLOTS + 2; i++)
			send_op(hir_pkg::FN_RESOLVE, {$urandom, $urandom} | 64'd1, 32'd3, 64'd0);
		send_op(hir_pkg::FN_BIND, 64'd77, 32'd77, 64'h7777);
		send_op(hir_pkg::FN_ROLLBACK, 64'd0, 32'd0, 64'd0);
		send_op(hir_pkg::FN_CLEAR, 64'd0, 32'd0, 64'd0);
		quiet = 1'b0;
		drain();

		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i == NUM_RANDOM / 2) drain();
			if (i == NUM_RANDOM - 100) quiet = 1'b1;
			send(random_req());
		end
		drain();
		repeat (SLOTS + 50) @(posedge clk);
		if (board.pending.size() != 0) report("responses left over", board.pending.size(), 0);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
